### rtl/srmv_pkg.sv
// Shared constants for the sparse row matrix-vector multiply unit.
// Field widths, parameter defaults and function codes.
// No dependencies; compile first.
package srmv_pkg;

	// Field widths fixed by the interface
	localparam int FUNC_W  = 2;
	localparam int INDEX_W = 12;
	localparam int VALUE_W = 32;
	localparam int ROW_W   = 16;
	localparam int SUM_W   = 64;

	// Parameter defaults
	localparam int VECTOR_LENGTH_DEF = 4096;
	localparam int VALUE_BITS_DEF    = 32;

	// Function codes on the input channel
	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EMPTY   = 2'd2;

	// Saturation limits of the row sum
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

### rtl/srmv_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and updated only on read enable.
// No dependencies.
module srmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/sparse_row_matrix_vector_multiply_unit.sv
// Sparse row matrix times dense vector, Q16.16 operands, Q32.32 row sums.
// Depends on srmv_pkg and srmv_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per item:
//   func 0 loads x[index], func 1 is a nonzero (index = column), func 2
//   closes an empty row. last_in_row on a nonzero closes the row; last_row
//   on a closing item restarts the row count at zero.
//   Output channel (out_valid / out_stall) carries one transaction per closed
//   row: row_index, saturated row_sum, and the sticky overflow flag.
// Throughput: one item per cycle when not stalled, nonzeros back to back;
//   the accumulator is a saturating add loop, the store a one-port-read RAM.
// Path: an accepted closing item moves through the store read, the multiply
//   register and then the accumulate into the output register, where its
//   result shows.
// Reset: the vector store is swept to zero one entry per cycle over all
//   min(VECTOR_LENGTH, 4096) entries; in_stall stays high meanwhile.
// Stall: a waiting result holds in the output register; the input keeps
//   taking items until the store read and multiply stages are both full
//   behind it, then in_stall rises.
module sparse_row_matrix_vector_multiply_unit #(
	parameter int VECTOR_LENGTH = srmv_pkg::VECTOR_LENGTH_DEF,
	parameter int VALUE_BITS    = srmv_pkg::VALUE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [srmv_pkg::FUNC_W-1:0]         func,
	input  logic [srmv_pkg::INDEX_W-1:0]        index,
	input  logic signed [srmv_pkg::VALUE_W-1:0] value,
	input  logic                                last_in_row,
	input  logic                                last_row,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [srmv_pkg::ROW_W-1:0]          row_index,
	output logic signed [srmv_pkg::SUM_W-1:0]   row_sum,
	output logic                                overflow
);

	import srmv_pkg::*;

	// Only indexes that the column field can reach get storage
	localparam int STORE_DEPTH = (VECTOR_LENGTH > (1 << INDEX_W)) ?
		(1 << INDEX_W) : VECTOR_LENGTH;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = 2 * VALUE_BITS;

	// Clear sweep state
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	// Stage 1: store read in flight
	logic                         valid_s1, close_s1, mac_s1, last_row_s1, in_range_s1;
	logic signed [VALUE_BITS-1:0] a_s1;

	// Stage 2: registered product
	logic                    valid_s2, close_s2, last_row_s2;
	logic signed [SUM_W-1:0] prod_s2;

	// Row state
	logic [SUM_W-1:0] acc_q;
	logic             ovf_q;
	logic [ROW_W-1:0] row_cnt_q;

	// Output register
	logic             out_valid_q;
	logic [ROW_W-1:0] row_index_q;
	logic [SUM_W-1:0] row_sum_q;
	logic             overflow_q;

	// Handshake and flow
	logic accept, enters_s1, load_s2, fire_s2, out_free, s1_free;
	logic in_range;
	logic [AW-1:0] addr;

	assign out_free = !out_valid_q || !out_stall;
	assign fire_s2  = valid_s2 && (!close_s2 || out_free);
	assign load_s2  = valid_s1 && (!valid_s2 || fire_s2);
	assign s1_free  = !valid_s1 || load_s2;
	assign in_stall = clr_q || !s1_free;
	assign accept   = in_valid && !in_stall;
	assign enters_s1 = accept && (func == FUNC_NONZERO || func == FUNC_EMPTY);

	assign in_range = int'(index) < STORE_DEPTH;
	assign addr     = AW'(index);

	// Vector store: clear sweep, loads, and nonzero reads
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;

	assign ram_we    = clr_q || (accept && func == FUNC_LOAD && in_range);
	assign ram_waddr = clr_q ? clr_addr_q : addr;
	assign ram_wdata = clr_q ? '0 : value[VALUE_BITS-1:0];
	assign ram_re    = enters_s1 && func == FUNC_NONZERO;

	srmv_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	// Sweep the store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Stage 1: capture the nonzero operand while the store reads x
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enters_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enters_s1) begin
			mac_s1      <= (func == FUNC_NONZERO);
			close_s1    <= (func == FUNC_EMPTY) || last_in_row;
			last_row_s1 <= last_row;
			in_range_s1 <= in_range;
			a_s1        <= value[VALUE_BITS-1:0];
		end
	end

	// Multiply: an out-of-range column reads x as zero
	logic signed [VALUE_BITS-1:0] x_s1;
	logic signed [PW-1:0]         prod;

	assign x_s1 = in_range_s1 ? $signed(ram_rdata) : '0;
	assign prod = a_s1 * x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (fire_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_s2     <= mac_s1 ? SUM_W'(prod) : '0;
			close_s2    <= close_s1;
			last_row_s2 <= last_row_s1;
		end
	end

	// Saturating accumulate
	logic [SUM_W-1:0] sum, sat_sum;
	logic             sat_det;

	assign sum     = acc_q + prod_s2;
	assign sat_det = (acc_q[SUM_W-1] == prod_s2[SUM_W-1]) &&
		(sum[SUM_W-1] != acc_q[SUM_W-1]);
	assign sat_sum = sat_det ? (acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum;

	// Advance the row state; on a row close load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			ovf_q       <= 1'b0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s2) begin
				if (close_s2) begin
					acc_q     <= '0;
					ovf_q     <= 1'b0;
					row_cnt_q <= last_row_s2 ? '0 : row_cnt_q + 1'b1;
				end else begin
					acc_q <= sat_sum;
					ovf_q <= ovf_q | sat_det;
				end
			end
			if (fire_s2 && close_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s2 && close_s2) begin
			row_index_q <= row_cnt_q;
			row_sum_q   <= sat_sum;
			overflow_q  <= ovf_q | sat_det;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_sum   = row_sum_q;
	assign overflow  = overflow_q;

endmodule

### rtl/srmv_checker.sv
// Port-level checker for the sparse row matrix-vector multiply unit.
// Tracks row-closing transactions in flight; bound to the top level below.
// Depends on srmv_pkg.
module srmv_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [srmv_pkg::FUNC_W-1:0]         func,
	input logic                                last_in_row,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [srmv_pkg::ROW_W-1:0]          row_index,
	input logic signed [srmv_pkg::SUM_W-1:0]   row_sum,
	input logic                                overflow
);

	import srmv_pkg::*;

	logic       close_in, take_out;
	logic [2:0] pend_q;

	assign close_in = in_valid && !in_stall &&
		(func == FUNC_EMPTY || (func == FUNC_NONZERO && last_in_row));
	assign take_out = out_valid && !out_stall;

	// Count closed rows whose result is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b0, close_in} - {2'b0, take_out};
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row_sum) &&
		$stable(row_index) && $stable(overflow))
		else $error("stalled result changed");

	// Never show a result without a closed row behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a closed row");

	// At most three rows in flight: store read, multiply, output
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("too many rows in flight");

	// Full pipeline behind a stalled result must stall the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd3 && out_stall |-> in_stall)
		else $error("input taken with a full pipeline");

endmodule

bind sparse_row_matrix_vector_multiply_unit srmv_checker u_srmv_checker (.*);

### test/testbench.sv
// Self-checking testbench for the sparse row matrix-vector multiply unit.
// Drives loads, nonzeros and row closes; checks row results against predicted or typed ones.
// Depends on srmv_pkg and the unit's RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import srmv_pkg::*;

	// Function code the unit ignores
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1650;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [INDEX_W-1:0] index;
		logic signed [VALUE_W-1:0] value;
		logic last_in_row;
		logic last_row;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic signed [SUM_W-1:0] sum;
		logic ovf;
	} row_result_t;

	typedef struct packed {
		item_t item;
		logic typed;
		row_result_t want;
	} dir_row_t;

	localparam row_result_t NO_ROW = '0;

	// Directed rows; typed expectations only where the answer is obvious
	localparam dir_row_t DIRECTED [21] = '{
		// after reset the store is zero: row 0 sums to zero
		'{'{FUNC_NONZERO, 12'd0, 32'sh7FFF_FFFF, 1'b1, 1'b0}, 1'b1, '{16'd0, 64'sd0, 1'b0}},
		// empty row right after
		'{'{FUNC_EMPTY, 12'd0, 32'sh0, 1'b0, 1'b0}, 1'b1, '{16'd1, 64'sd0, 1'b0}},
		// unused code: no result, no state change
		'{'{FUNC_UNUSED, 12'd5, 32'sh1234_5678, 1'b1, 1'b1}, 1'b0, NO_ROW},
		// loads, one with both flags set
		'{'{FUNC_LOAD, 12'd0, 32'sh8000_0000, 1'b1, 1'b1}, 1'b0, NO_ROW},
		'{'{FUNC_LOAD, 12'd4095, 32'sh7FFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_LOAD, 12'd1, 32'sh0001_0000, 1'b0, 1'b1}, 1'b0, NO_ROW},
		// two min*min products saturate high, then a negative term pulls back
		'{'{FUNC_NONZERO, 12'd0, 32'sh8000_0000, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd0, 32'sh8000_0000, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd4095, 32'sh8000_0000, 1'b1, 1'b0}, 1'b0, NO_ROW},
		// last row of the matrix restarts the row number
		'{'{FUNC_NONZERO, 12'd1, 32'sh0002_0000, 1'b1, 1'b1}, 1'b0, NO_ROW},
		'{'{FUNC_EMPTY, 12'd4095, 32'shFFFF_FFFF, 1'b0, 1'b0}, 1'b1, '{16'd0, 64'sd0, 1'b0}},
		// last_row without a row end is ignored
		'{'{FUNC_NONZERO, 12'd1, 32'sh0000_0001, 1'b0, 1'b1}, 1'b0, NO_ROW},
		// empty row closes with the pending accumulator
		'{'{FUNC_EMPTY, 12'd0, 32'sh0, 1'b1, 1'b0}, 1'b0, NO_ROW},
		// negative saturation, then a positive term
		'{'{FUNC_LOAD, 12'd2, 32'sh7FFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd0, 32'sh7FFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd0, 32'sh7FFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd0, 32'sh7FFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd1, 32'sh7FFF_FFFF, 1'b1, 1'b0}, 1'b0, NO_ROW},
		// max*max twice stays just below the limit
		'{'{FUNC_NONZERO, 12'd2, 32'sh7FFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd2, 32'sh7FFF_FFFF, 1'b1, 1'b1}, 1'b0, NO_ROW},
		'{'{FUNC_NONZERO, 12'd0, 32'sh8000_0000, 1'b1, 1'b0}, 1'b0, NO_ROW}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [FUNC_W-1:0] func = '0;
	logic [INDEX_W-1:0] index = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic last_in_row = 1'b0;
	logic last_row = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ROW_W-1:0] row_index;
	logic signed [SUM_W-1:0] row_sum;
	logic overflow;

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int mismatch_count = 0;
	row_result_t pending_rows [$];

	// Predictor state
	logic signed [VALUE_W-1:0] x_store [VECTOR_LENGTH_DEF];
	logic signed [SUM_W-1:0] acc;
	logic acc_ovf;
	logic [ROW_W-1:0] row_count;

	sparse_row_matrix_vector_multiply_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.index(index),
		.value(value),
		.last_in_row(last_in_row),
		.last_row(last_row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.row_index(row_index),
		.row_sum(row_sum),
		.overflow(overflow)
	);

	always #1 clk = ~clk;

	// Apply one item to the predictor; return 1 when it closes a row
	function automatic bit spmv_step(input item_t it, output row_result_t res);
		logic signed [SUM_W-1:0] a_ext, x_ext, term, total;
		bit closes;
		closes = 1'b0;
		res = '0;
		case (it.func)
		FUNC_LOAD: begin
			x_store[it.index] = it.value;
		end
		FUNC_NONZERO: begin
			a_ext = it.value;
			x_ext = x_store[it.index];
			term = a_ext * x_ext;
			total = acc + term;
			// saturate each addition on its own, flag stays sticky
			if (acc[SUM_W-1] == term[SUM_W-1] && total[SUM_W-1] != acc[SUM_W-1]) begin
				acc_ovf = 1'b1;
				total = acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
			end
			acc = total;
			closes = it.last_in_row;
		end
		FUNC_EMPTY: begin
			closes = 1'b1;
		end
		default: ;
		endcase
		if (closes) begin
			res = '{row_count, acc, acc_ovf};
			acc = '0;
			acc_ovf = 1'b0;
			row_count = it.last_row ? '0 : row_count + 1'b1;
		end
		return closes;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		pick = $urandom_range(99);
		it.func = pick < 19 ? FUNC_LOAD : pick < 88 ? FUNC_NONZERO
			: pick < 97 ? FUNC_EMPTY : FUNC_UNUSED;
		// mostly a small column set so nonzeros hit loaded elements
		it.index = $urandom_range(99) < 70 ? INDEX_W'($urandom_range(31)) : INDEX_W'($urandom);
		case ($urandom_range(4))
		0: begin
			it.value = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		end
		1: begin
			it.value = $urandom_range(1) ? VALUE_W'($urandom_range(32'h0003_FFFF))
				: -VALUE_W'($urandom_range(32'h0003_FFFF));
		end
		default: begin
			it.value = $urandom;
		end
		endcase
		it.last_in_row = it.func == FUNC_NONZERO ? ($urandom_range(99) < 18)
			: 1'($urandom_range(1));
		it.last_row = $urandom_range(9) == 0;
		return it;
	endfunction

	// Drive one transaction, hold it until accepted, then predict
	task automatic send_item(input item_t it, input bit typed, input row_result_t want);
		row_result_t res;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		index <= it.index;
		value <= it.value;
		last_in_row <= it.last_in_row;
		last_row <= it.last_row;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (spmv_step(it, res))
			pending_rows.push_back(typed ? want : res);
		@(negedge clk);
	endtask

	// Receiver backpressure
	always @(negedge clk) begin
		out_stall <= $urandom_range(99) < sink_stall_pct;
	end

	// Check each accepted row result against the oldest expectation
	always @(posedge clk) begin
		row_result_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{row_index, row_sum, overflow};
			if (pending_rows.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected row result, expected none, got row %0d sum %h ovf %0b",
					$time, got.row, got.sum, got.ovf);
			end else begin
				want = pending_rows.pop_front();
				if (got.row !== want.row || got.sum !== want.sum || got.ovf !== want.ovf) begin
					mismatch_count++;
					$display("%0t: expected row %0d sum %h ovf %0b, got row %0d sum %h ovf %0b",
						$time, want.row, want.sum, want.ovf, got.row, got.sum, got.ovf);
				end
			end
		end
	end

	// Stimulus
	initial begin
		item_t it;
		int sent;
		foreach (x_store[i])
			x_store[i] = '0;
		acc = '0;
		acc_ovf = 1'b0;
		row_count = '0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

		// slow receiver, then slow sender, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = phase == 0 ? 8 : phase == 1 ? 85 : 0;
			sink_stall_pct = phase == 0 ? 85 : phase == 1 ? 8 : 0;
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				it = random_item();
				send_item(it, 1'b0, NO_ROW);
				if (it.func != FUNC_UNUSED)
					sent++;
			end
		end
		in_valid <= 1'b0;

		// drain, then allow for stray results
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog
	initial begin
		#1_500_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
rtl/srmv_pkg.sv
rtl/srmv_ram.sv
rtl/sparse_row_matrix_vector_multiply_unit.sv
rtl/srmv_checker.sv
test/testbench.sv
